// File: hw/rtl/custom_isa_execute_unit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the custom ISA execute unit
// Immediate and next-cycle implications, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_ISA_EXECUTE_UNIT_CORE_MACROS_SVH
`define CUSTOM_ISA_EXECUTE_UNIT_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg
// Shared types, opcodes and constants of the custom ISA execute unit.
// ----------------------------------------------------------------------------
package cie_pkg;

  localparam int unsigned MEM_WORDS_DEFAULT = 4096;
  // Word address width: byte address with the two offset bits dropped.
  localparam int unsigned WORD_W = 30;

  localparam logic [5:0] OP_ADD  = 6'd0;
  localparam logic [5:0] OP_COMP = 6'd10;
  localparam logic [5:0] OP_ADDI = 6'd11;
  localparam logic [5:0] OP_COMPI = 6'd21;
  localparam logic [5:0] OP_LW   = 6'd22;
  localparam logic [5:0] OP_LTH  = 6'd23;
  localparam logic [5:0] OP_LH   = 6'd24;
  localparam logic [5:0] OP_LB   = 6'd25;
  localparam logic [5:0] OP_LI   = 6'd26;
  localparam logic [5:0] OP_LUI  = 6'd27;
  localparam logic [5:0] OP_LNI  = 6'd28;
  localparam logic [5:0] OP_SW   = 6'd29;
  localparam logic [5:0] OP_SH   = 6'd30;
  localparam logic [5:0] OP_SB   = 6'd31;
  localparam logic [5:0] OP_STH  = 6'd32;
  localparam logic [5:0] OP_J    = 6'd33;
  localparam logic [5:0] OP_JAL  = 6'd34;
  localparam logic [5:0] OP_JR   = 6'd35;
  localparam logic [5:0] OP_JRL  = 6'd36;
  localparam logic [5:0] OP_BEQ  = 6'd37;
  localparam logic [5:0] OP_BNE  = 6'd38;
  localparam logic [5:0] OP_BGT  = 6'd39;
  localparam logic [5:0] OP_BLT  = 6'd40;

  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] pc;
    logic [31:0] rsa;
    logic [31:0] rsb;
    logic [21:0] imm;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        writes_value;
    logic [31:0] next_pc;
    logic        pc_changed;
    logic        taken;
    logic        mem_we;
    logic [31:0] mem_wdata;
  } exec_res_t;

endpackage

// File: hw/rtl/cie_ram.sv
// ----------------------------------------------------------------------------
// cie_ram
// Data word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cie_ram #(
  parameter int unsigned DEPTH = cie_pkg::MEM_WORDS_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read before write: a same-cycle write is forwarded by the caller.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cie_index.sv
// ----------------------------------------------------------------------------
// cie_index
// Word index pipeline: reduce the word address modulo the memory depth.
// ----------------------------------------------------------------------------
module cie_index #(
  parameter int unsigned MEM_WORDS = cie_pkg::MEM_WORDS_DEFAULT,
  parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cie_pkg::WORD_W-1:0] word_in,
  output logic [AW-1:0]             idx
);
  import cie_pkg::*;

  localparam int unsigned L  = $clog2(MEM_WORDS);
  localparam int unsigned K  = WORD_W + L;
  localparam int unsigned RW = WORD_W + 1;
  // Floor reciprocal: the quotient estimate is low by at most one.
  localparam logic [RW-1:0]     RECIP = RW'((64'd1 << K) / 64'(MEM_WORDS));
  localparam logic [WORD_W-1:0] M_W   = WORD_W'(MEM_WORDS);

  logic [WORD_W-1:0]    x_a;
  logic [WORD_W-1:0]    x_b;
  logic [WORD_W-1:0]    q_b;
  logic [WORD_W+RW-1:0] prod;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    rem_fix;

  assign prod = x_a * RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      x_a <= word_in;
      x_b <= x_a;
      q_b <= WORD_W'(prod >> K);
    end
  end

  always_comb begin
    rem     = x_b - WORD_W'(q_b * M_W);
    rem_fix = (rem >= M_W) ? (rem - M_W) : rem;
    idx     = rem_fix[AW-1:0];
  end

endmodule

// File: hw/rtl/cie_exec.sv
// ----------------------------------------------------------------------------
// cie_exec
// Execute logic: ALU, load extraction, store merge, jumps and branches.
// ----------------------------------------------------------------------------
module cie_exec (
  input  cie_pkg::req_t      req,
  input  logic [31:0]        word,
  output cie_pkg::exec_res_t res
);
  import cie_pkg::*;

  localparam logic [3:0] K_ADD = 4'd0;
  localparam logic [3:0] K_SUB = 4'd1;
  localparam logic [3:0] K_NEG = 4'd2;
  localparam logic [3:0] K_AND = 4'd3;
  localparam logic [3:0] K_OR  = 4'd4;
  localparam logic [3:0] K_XOR = 4'd5;
  localparam logic [3:0] K_SAL = 4'd6;
  localparam logic [3:0] K_SAR = 4'd7;
  localparam logic [3:0] K_SLL = 4'd8;
  localparam logic [3:0] K_SLR = 4'd9;

  logic        reg_form;
  logic [3:0]  kind;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] cmp_b;
  logic        big;
  logic [31:0] alu_val;
  logic [31:0] s21;
  logic [31:0] s14;
  logic        cond;

  always_comb begin
    reg_form = (req.op <= OP_COMP);
    kind     = reg_form ? req.op[3:0] : 4'(req.op - OP_ADDI);
    a        = req.rsa;
    b        = reg_form ? req.rsb : {20'd0, req.imm[11:0]};
    cmp_b    = reg_form ? req.rsb : {16'd0, req.imm[15:0]};
    big      = |b[31:5];
    case (kind)
      K_ADD:   alu_val = a + b;
      K_SUB:   alu_val = a - b;
      K_NEG:   alu_val = reg_form ? ((b != 32'd0) ? (~a + 32'd1) : ~a) : ~b;
      K_AND:   alu_val = a & b;
      K_OR:    alu_val = a | b;
      K_XOR:   alu_val = a ^ b;
      K_SAL,
      K_SLL:   alu_val = big ? 32'd0 : (a << b[4:0]);
      K_SAR:   alu_val = big ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      K_SLR:   alu_val = big ? 32'd0 : (a >> b[4:0]);
      default: alu_val = (a > cmp_b) ? 32'hFFFF_FFFF - 32'hFFFF_FFFE
                       : ((a < cmp_b) ? 32'hFFFF_FFFE : 32'd0);
    endcase
  end

  always_comb begin
    s21 = {{11{req.imm[20]}}, req.imm[20:0]};
    s14 = {{18{req.imm[13]}}, req.imm[13:0]};
    case (req.op)
      OP_BEQ:  cond = (req.rsa == req.rsb);
      OP_BNE:  cond = (req.rsa != req.rsb);
      OP_BGT:  cond = ($signed(req.rsb) < $signed(req.rsa));
      default: cond = ($signed(req.rsa) < $signed(req.rsb));
    endcase
  end

  always_comb begin
    res              = '0;
    res.next_pc      = req.pc;
    unique case (req.op) inside
      [OP_ADD:OP_COMPI]: begin
        res.value        = alu_val;
        res.writes_value = 1'b1;
      end
      OP_LW:  begin res.value = word;                 res.writes_value = 1'b1; end
      OP_LTH: begin res.value = {8'd0, word[31:8]};   res.writes_value = 1'b1; end
      OP_LH:  begin res.value = {16'd0, word[31:16]}; res.writes_value = 1'b1; end
      OP_LB:  begin res.value = {24'd0, word[31:24]}; res.writes_value = 1'b1; end
      OP_LI: begin
        res.value        = {{16{req.imm[15]}}, req.imm[15:0]};
        res.writes_value = 1'b1;
      end
      OP_LUI: begin res.value = {req.imm[15:0], 16'd0}; res.writes_value = 1'b1; end
      OP_LNI: begin res.value = {16'd0, req.imm[15:0]}; res.writes_value = 1'b1; end
      OP_SW:  begin res.mem_we = 1'b1; res.mem_wdata = req.rsb; end
      OP_SH:  begin res.mem_we = 1'b1; res.mem_wdata = {req.rsb[15:0], word[15:0]}; end
      OP_SB:  begin res.mem_we = 1'b1; res.mem_wdata = {req.rsb[7:0], word[23:0]}; end
      OP_STH: begin res.mem_we = 1'b1; res.mem_wdata = {req.rsb[23:0], word[7:0]}; end
      [OP_J:OP_JRL]: begin
        if ((req.op == OP_JR || req.op == OP_JRL) && req.rsa != 32'd0) begin
          res.next_pc = req.pc + req.rsa + {10'd0, req.imm};
        end else if (req.op == OP_JAL || req.op == OP_JRL) begin
          res.next_pc = s21 + 32'd4;
        end else begin
          res.next_pc = req.pc + s21 + 32'd4;
        end
        if (req.op == OP_JAL || req.op == OP_JRL) begin
          res.value        = req.pc + 32'd4;
          res.writes_value = 1'b1;
        end
        res.pc_changed = 1'b1;
        res.taken      = 1'b1;
      end
      [OP_BEQ:OP_BLT]: begin
        res.next_pc    = req.pc + (cond ? s14 : 32'd4);
        res.pc_changed = 1'b1;
        res.taken      = cond;
      end
      default: begin
        res.next_pc = req.pc;
      end
    endcase
  end

endmodule

// File: hw/rtl/custom_isa_execute_unit_core.sv
// ----------------------------------------------------------------------------
// custom_isa_execute_unit_core
// Execute stage of a small custom 32-bit ISA with a word data memory.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  request   | in_valid / in_ready       | op, pc, rsa, rsb, imm
//  result    | out_valid / out_ready     | value, writes_value, next_pc,
//            |                           | pc_changed, taken
//  config    | cfg_we (no wait)          | cfg_wdata -> segment_base
//
//  One request a cycle, sustained unless the result stalls. The rate is set
//  by the single data memory port pair: the read of one request and the
//  store write-back of the one ahead share a cycle.
//  Pipeline: address add on intake, A (index reciprocal multiply), B (index
//  remainder, memory read), C (read data, execute, store write-back), then
//  the output register.
//  Reset clears the valid bits and segment_base; memory contents are left
//  as they are; loads must not read an unwritten word, the block does not enforce it.
//  A stalled result freezes the whole pipeline, memory read included.
// ----------------------------------------------------------------------------
module custom_isa_execute_unit_core #(
  parameter int unsigned MEM_WORDS = cie_pkg::MEM_WORDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  op,
  input  logic [31:0] pc,
  input  logic [31:0] rsa,
  input  logic [31:0] rsb,
  input  logic [21:0] imm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic        writes_value,
  output logic [31:0] next_pc,
  output logic        pc_changed,
  output logic        taken
);
  import cie_pkg::*;

  `include "custom_isa_execute_unit_core_macros.svh"

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0]       segment_base;
  logic              en;
  logic [31:0]       byte_addr;
  logic [AW-1:0]     b_idx;

  logic              a_valid;
  logic              b_valid;
  logic              c_valid;
  req_t              a_req;
  req_t              b_req;
  req_t              c_req;
  logic [AW-1:0]     c_idx;
  logic              c_fwd;
  logic [31:0]       c_fwd_word;

  logic [31:0]       rdata;
  logic [31:0]       c_word;
  exec_res_t         res;
  logic              mem_we;

  // Advance everything together unless the result register is held.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_base <= 32'd0;
    end else if (cfg_we) begin
      segment_base <= cfg_wdata;
    end
  end

  // Effective byte address relative to the segment start.
  assign byte_addr = rsa + {18'd0, imm[13:0]} - segment_base;

  cie_index #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_index (
    .clk     (clk),
    .en      (en),
    .word_in (byte_addr[31:2]),
    .idx     (b_idx)
  );

  // Store write-back happens as the request leaves stage C.
  assign mem_we = en && c_valid && res.mem_we;

  cie_ram #(
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (c_idx),
    .wdata (res.mem_wdata),
    .re    (en),
    .raddr (b_idx),
    .rdata (rdata)
  );

  // The read of the request entering C misses the write made in the same
  // cycle; take the written word instead when the index matches.
  assign c_word = c_fwd ? c_fwd_word : rdata;

  cie_exec u_exec (
    .req  (c_req),
    .word (c_word),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // Payload registers: no reset, advance with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      a_req        <= '{op: op, pc: pc, rsa: rsa, rsb: rsb, imm: imm};
      b_req        <= a_req;
      c_req        <= b_req;
      c_idx        <= b_idx;
      c_fwd        <= mem_we && (b_idx == c_idx);
      c_fwd_word   <= res.mem_wdata;
      value        <= res.value;
      writes_value <= res.writes_value;
      next_pc      <= res.next_pc;
      pc_changed   <= res.pc_changed;
      taken        <= res.taken;
    end
  end

  // A held result must freeze intake.
  `CIE_ASSERT_NOW(a_stall_blocks_intake, out_valid && !out_ready, !in_ready,
                  "request accepted while result stalled")
  // Memory writes only from a valid request leaving stage C.
  `CIE_ASSERT_NOW(a_write_from_c, mem_we, c_valid && en && res.mem_we,
                  "memory write without a store in stage C")
  // A store hitting the entry just read must be forwarded.
  `CIE_ASSERT_NEXT(a_forward_taken, mem_we && (b_idx == c_idx), c_fwd,
                   "same-entry store not forwarded")

endmodule
